// ----- src/mpmr_pkg.sv -----
// Package for the multi-pattern match reporter: item kind codes, field widths
// and the per-node info record kept in the node info memory.
// No dependencies.
`default_nettype none

package mpmr_pkg;

    // Width of one byte-sized field of the input and result words
    localparam int FIELD_W = 8;
    // Width of the reported match start
    localparam int START_W = 32;
    // tuser width on the slave side (item kind)
    localparam int KIND_W = 2;
    // Five byte fields on the slave side: node, byte, next node, length, pattern
    localparam int S_DATA_W = 5 * FIELD_W;
    // Start, length and pattern on the master side
    localparam int M_DATA_W = START_W + 2 * FIELD_W;

    // What a slave-side word carries
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_GOTO = 2'd0,
        KIND_LOAD_INFO = 2'd1,
        KIND_DATA      = 2'd2,
        KIND_RESTART   = 2'd3
    } kind_t;

    // Node info entry: longest match ending at the node and its pattern id
    typedef struct packed {
        logic [FIELD_W-1:0] pattern;
        logic [FIELD_W-1:0] length;
    } node_info_t;

endpackage

`default_nettype wire

// ----- src/multi_pattern_match_reporter.sv -----
// Streaming multi-pattern matcher over a loaded complete goto table (DFA form).
// Holds the goto memory, the node info memory and the match pipeline.
// Depends on mpmr_pkg.
`default_nettype none

// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+-------------------------------------------
// s_      | in  | s_tvalid/s_tready  | tuser: kind; tdata: node, byte_value,
//         |     |                    |   next_node, match_length, pattern_id
// m_      | out | m_tvalid/m_tready  | tdata: found_start, found_length,
//         |     |                    |   found_pattern
//
// One word per cycle unless stalled, data bytes included: the goto memory
// read data of one byte feeds the address of the next byte directly.
// A match reaches m_ through the goto read at the accepting edge, the node
// info read and the output register, in that order.
// Reset clears the current node, the byte position and the node info valid
// bits; the goto memory needs no clearing. Loaded tables survive a restart.
// The pipeline stalls only when a hit reaches the last stage while the output
// register still holds an untaken word.
module multi_pattern_match_reporter #(
    parameter int MAX_NODES     = 256,
    parameter int ALPHABET      = 256,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // slave side
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] kind
    input  wire logic [mpmr_pkg::KIND_W-1:0]   s_tuser,
    // [7:0] node, [15:8] byte_value, [23:16] next_node,
    // [31:24] match_length, [39:32] pattern_id
    input  wire logic [mpmr_pkg::S_DATA_W-1:0] s_tdata,
    // master side
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] found_start, [39:32] found_length, [47:40] found_pattern
    output logic [mpmr_pkg::M_DATA_W-1:0]      m_tdata
);

    // Node fields are 8 bits wide, so at most 256 nodes are reachable
    localparam int NW         = (MAX_NODES > 256) ? 8 : $clog2(MAX_NODES);
    localparam int NODES      = 1 << NW;
    localparam int AW         = $clog2(ALPHABET);
    localparam int GOTO_DEPTH = 1 << (NW + AW);
    localparam int PW         = POSITION_BITS;
    localparam int SW         = (PW > mpmr_pkg::START_W) ? PW : mpmr_pkg::START_W;
    localparam int FW         = mpmr_pkg::FIELD_W;

    // Input word fields
    mpmr_pkg::kind_t   s_kind;
    logic [FW-1:0]     s_node;
    logic [FW-1:0]     s_byte;
    logic [FW-1:0]     s_next;
    logic [FW-1:0]     s_len;
    logic [FW-1:0]     s_pid;

    assign s_kind = mpmr_pkg::kind_t'(s_tuser);
    assign s_node = s_tdata[FW-1:0];
    assign s_byte = s_tdata[2*FW-1:FW];
    assign s_next = s_tdata[3*FW-1:2*FW];
    assign s_len  = s_tdata[4*FW-1:3*FW];
    assign s_pid  = s_tdata[5*FW-1:4*FW];

    // Memories
    logic [NW-1:0]          goto_mem [GOTO_DEPTH];
    mpmr_pkg::node_info_t   info_mem [NODES];

    // Control and pipeline registers
    logic [NODES-1:0]       info_vld_reg;
    logic [NW-1:0]          cur_reg;
    logic                   fwd_reg;
    logic                   oob_reg;
    logic [PW-1:0]          pos_reg;
    logic                   v1_reg;
    logic [PW-1:0]          pos1_reg;
    logic                   v2_reg;
    logic [PW-1:0]          pos2_reg;
    logic [NW-1:0]          goto_rdata_reg;
    mpmr_pkg::node_info_t   info_rdata_reg;
    logic                   info_vbit_reg;
    logic                   m_tvalid_reg;
    logic [mpmr_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Combinational
    logic                   adv;
    logic                   accept;
    logic                   node_ok;
    logic                   next_ok;
    logic                   byte_ok;
    logic [NW-1:0]          node_idx;
    logic [NW-1:0]          target;
    logic [AW-1:0]          byte_idx;
    logic [NW-1:0]          cur_sel;
    logic [PW-1:0]          pos_inc;
    logic                   s2_hit;
    logic [PW-1:0]          len_ext;
    logic [PW-1:0]          diff;
    logic [SW-1:0]          diff_wide;

    // Range checks on the load and data fields
    assign node_ok  = (32'(s_node) < MAX_NODES);
    assign next_ok  = (32'(s_next) < MAX_NODES);
    assign byte_ok  = (32'(s_byte) < ALPHABET);
    assign node_idx = s_node[NW-1:0];
    assign target   = next_ok ? s_next[NW-1:0] : '0;
    assign byte_idx = s_byte[AW-1:0];

    // Current node: read data of the last data byte, or the committed node
    assign cur_sel = fwd_reg ? (oob_reg ? '0 : goto_rdata_reg) : cur_reg;

    // Saturating byte position
    assign pos_inc = (pos_reg == {PW{1'b1}}) ? pos_reg : pos_reg + PW'(1);

    // Last stage: hit when the node has a loaded nonzero match length
    assign s2_hit = v2_reg && info_vbit_reg && (info_rdata_reg.length != '0);

    // Freeze only when a hit cannot move into the output register
    assign adv      = !(m_tvalid_reg && !m_tready && s2_hit);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // Match start from the position counted through this byte
    assign len_ext   = PW'(info_rdata_reg.length);
    assign diff      = (pos2_reg >= len_ext) ? pos2_reg - len_ext : '0;
    assign diff_wide = SW'(diff);

    // Goto memory: one write port for loads, one read per data byte
    always_ff @(posedge aclk) begin
        if (accept && s_kind == mpmr_pkg::KIND_LOAD_GOTO && node_ok && byte_ok) begin
            goto_mem[{node_idx, byte_idx}] <= target;
        end
        if (accept && s_kind == mpmr_pkg::KIND_DATA && byte_ok) begin
            goto_rdata_reg <= goto_mem[{cur_sel, byte_idx}];
        end
    end

    // Node info memory: written by info loads, read at the node just reached
    always_ff @(posedge aclk) begin
        if (accept && s_kind == mpmr_pkg::KIND_LOAD_INFO && node_ok) begin
            info_mem[node_idx] <= '{pattern: s_pid, length: s_len};
        end
        if (adv && v1_reg) begin
            info_rdata_reg <= info_mem[cur_sel];
        end
    end

    // Info valid bits: unloaded nodes read as match length zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            info_vld_reg  <= '0;
            info_vbit_reg <= 1'b0;
        end else begin
            if (accept && s_kind == mpmr_pkg::KIND_LOAD_INFO && node_ok) begin
                info_vld_reg[node_idx] <= 1'b1;
            end
            if (adv && v1_reg) begin
                info_vbit_reg <= info_vld_reg[cur_sel];
            end
        end
    end

    // Current node and byte position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            fwd_reg <= 1'b0;
            oob_reg <= 1'b0;
            pos_reg <= '0;
        end else if (accept) begin
            case (s_kind)
                mpmr_pkg::KIND_DATA: begin
                    cur_reg <= cur_sel;
                    fwd_reg <= 1'b1;
                    oob_reg <= !byte_ok;
                    pos_reg <= pos_inc;
                end
                mpmr_pkg::KIND_RESTART: begin
                    cur_reg <= '0;
                    fwd_reg <= 1'b0;
                    pos_reg <= '0;
                end
                mpmr_pkg::KIND_LOAD_GOTO, mpmr_pkg::KIND_LOAD_INFO: begin
                    cur_reg <= cur_sel;
                    fwd_reg <= 1'b0;
                end
                default: begin
                    cur_reg <= cur_sel;
                end
            endcase
        end
    end

    // Pipeline valids and positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept && (s_kind == mpmr_pkg::KIND_DATA);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos1_reg <= pos_inc;
            pos2_reg <= pos1_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (adv && s2_hit) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_hit) begin
            m_tdata_reg <= {info_rdata_reg.pattern, info_rdata_reg.length,
                            diff_wide[mpmr_pkg::START_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
